FILE: hw/rtl/erle_pkg.sv
// Shared types and constants for the escape-byte run-length decoder.
package erle_pkg;

    // Field widths
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned SIZE_W  = 16;

    // Packed output tdata width: value and count rounded up to whole bytes
    localparam int unsigned OUT_TDATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;

    // Image size after reset
    localparam logic [SIZE_W-1:0] IMAGE_BYTES_RESET = 16'd32000;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SKIP   = 3'd1,
        PH_DATA   = 3'd2,
        PH_COUNT  = 3'd3,
        PH_VALUE  = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    // One compressed input byte with its file marker
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              file_start;
    } item_t;

    // One decoded run
    typedef struct packed {
        logic [DATA_W-1:0]  out_value;
        logic [COUNT_W-1:0] repeat_count;
        logic               image_done;
    } result_t;

endpackage

FILE: hw/rtl/escape_rle_byte_decoder_top.sv
// Escape-byte run-length decoder: at most one run out per compressed byte.
// The decoder takes one compressed byte per clock while the output is taken: each byte passes
// an input register, the parser logic (escape compare, run clip against the remaining byte cap)
// and a result register. The first byte of a file (s_tuser high, or the first byte after reset)
// sets the escape value and the next byte is skipped; literal bytes come out with a count of one,
// escape/count/value triples as one run of count plus one. The result that fills the image,
// sized by cfg_data, is flagged with m_tlast; bytes after it are dropped until the next file
// start. A new size written on cfg_we applies from the next file start.
module escape_rle_byte_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: image size in bytes
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    // Compressed byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tuser,     // [0] file_start
    // Decoded runs
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [7:0] out_value, [16:8] repeat_count, [23:17] zero
    output logic        m_tlast      // image_done
);

    erle_pkg::item_t   in_item;
    erle_pkg::item_t   item;
    logic              item_valid;
    logic              fire;
    logic              slot_free;
    logic              res_valid;
    erle_pkg::result_t res;
    erle_pkg::result_t out_res;

    assign in_item.data_byte  = s_tdata;
    assign in_item.file_start = s_tuser;

    // Process the held byte when the result slot can take its outcome
    assign fire = item_valid && slot_free;

    erle_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (fire)
    );

    erle_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    erle_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res_valid (res_valid),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the run onto the output bus
    assign m_tdata = {(erle_pkg::OUT_TDATA_W - erle_pkg::DATA_W - erle_pkg::COUNT_W)'(0),
                      out_res.repeat_count, out_res.out_value};
    assign m_tlast = out_res.image_done;

endmodule

FILE: hw/rtl/erle_in_stage.sv
// Input register stage of the escape-byte run-length decoder.
module erle_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  erle_pkg::item_t     in_item,
    output logic                item_valid,
    output erle_pkg::item_t     item,
    input  logic                item_take
);

    logic            valid_reg;
    logic            valid_next;
    erle_pkg::item_t item_reg;

    // Accept a new byte whenever the held one is empty or leaves this cycle
    assign in_ready = !valid_reg || item_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on each transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hw/rtl/erle_parser.sv
// Escape/count/value parser with the byte cap of the decoder.
module erle_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    input  logic                fire,
    input  erle_pkg::item_t     item,
    output logic                res_valid,
    output erle_pkg::result_t   res
);

    erle_pkg::phase_t                   phase_reg;
    erle_pkg::phase_t                   phase_next;
    logic [erle_pkg::DATA_W-1:0]        escape_value_reg;
    logic [erle_pkg::DATA_W-1:0]        escape_value_next;
    logic [erle_pkg::COUNT_W-1:0]       pending_count_reg;
    logic [erle_pkg::COUNT_W-1:0]       pending_count_next;
    logic [erle_pkg::SIZE_W-1:0]        bytes_left_reg;
    logic [erle_pkg::SIZE_W-1:0]        bytes_left_next;
    logic [erle_pkg::SIZE_W-1:0]        image_bytes_reg;

    logic                               restart;
    logic                               emit;
    logic [erle_pkg::SIZE_W-1:0]        load_size;
    logic [erle_pkg::COUNT_W-1:0]       run_count;
    logic [erle_pkg::COUNT_W-1:0]       clip_count;
    logic [erle_pkg::SIZE_W-1:0]        left_after;

    // Image size register, picked up at the next file start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_bytes_reg <= erle_pkg::IMAGE_BYTES_RESET;
        end
        else if (cfg_we)
        begin
            image_bytes_reg <= cfg_data;
        end
    end

    // A zero size counts as one byte
    assign load_size = (image_bytes_reg == '0) ? erle_pkg::SIZE_W'(1) : image_bytes_reg;

    assign restart = item.file_start || (phase_reg == erle_pkg::PH_HEADER);

    // Clip the run to the space left and work out what remains
    assign run_count  = (phase_reg == erle_pkg::PH_VALUE) ? pending_count_reg
                                                          : erle_pkg::COUNT_W'(1);
    assign clip_count = (erle_pkg::SIZE_W'(run_count) > bytes_left_reg)
                        ? bytes_left_reg[erle_pkg::COUNT_W-1:0] : run_count;
    assign left_after = bytes_left_reg - erle_pkg::SIZE_W'(clip_count);

    // Decide whether this byte gives a result
    always_comb
    begin
        emit = 1'b0;
        if (!restart)
        begin
            unique case (phase_reg)
                erle_pkg::PH_DATA:  emit = (item.data_byte != escape_value_reg);
                erle_pkg::PH_VALUE: emit = 1'b1;
                default:            emit = 1'b0;
            endcase
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            if (restart)
            begin
                phase_next = erle_pkg::PH_SKIP;
            end
            else
            begin
                unique case (phase_reg)
                    erle_pkg::PH_SKIP:
                    begin
                        phase_next = erle_pkg::PH_DATA;
                    end
                    erle_pkg::PH_DATA:
                    begin
                        if (!emit)
                        begin
                            phase_next = erle_pkg::PH_COUNT;
                        end
                        else if (left_after == '0)
                        begin
                            phase_next = erle_pkg::PH_DONE;
                        end
                    end
                    erle_pkg::PH_COUNT:
                    begin
                        phase_next = erle_pkg::PH_VALUE;
                    end
                    erle_pkg::PH_VALUE:
                    begin
                        phase_next = (left_after == '0) ? erle_pkg::PH_DONE
                                                        : erle_pkg::PH_DATA;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Data state and result fields
    always_comb
    begin
        escape_value_next  = escape_value_reg;
        pending_count_next = pending_count_reg;
        bytes_left_next    = bytes_left_reg;
        if (fire)
        begin
            if (restart)
            begin
                escape_value_next  = item.data_byte;
                pending_count_next = '0;
                bytes_left_next    = load_size;
            end
            else
            begin
                if (phase_reg == erle_pkg::PH_COUNT)
                begin
                    pending_count_next = erle_pkg::COUNT_W'(item.data_byte) + 1'b1;
                end
                if (emit)
                begin
                    bytes_left_next = left_after;
                end
            end
        end
        res_valid        = emit;
        res.out_value    = item.data_byte;
        res.repeat_count = clip_count;
        res.image_done   = (left_after == '0);
    end

    // Advance the parser state on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= erle_pkg::PH_HEADER;
            escape_value_reg  <= '0;
            pending_count_reg <= '0;
            bytes_left_reg    <= erle_pkg::IMAGE_BYTES_RESET;
        end
        else
        begin
            phase_reg         <= phase_next;
            escape_value_reg  <= escape_value_next;
            pending_count_reg <= pending_count_next;
            bytes_left_reg    <= bytes_left_next;
        end
    end

    // A run that fills the image ends the file
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid && res.image_done |=> phase_reg == erle_pkg::PH_DONE)
        else $error("image_done result did not end the file");

    // Every run writes at least one byte
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid |-> res.repeat_count != '0)
        else $error("empty run produced");

    // A finished image stays silent until a new file starts
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == erle_pkg::PH_DONE && !item.file_start |-> !res_valid)
        else $error("result after image was full");

    // A file start always reloads the byte cap
    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.file_start |=> bytes_left_reg != '0)
        else $error("byte cap not reloaded at file start");

endmodule

FILE: hw/rtl/erle_out_stage.sv
// Result register stage of the escape-byte run-length decoder.
module erle_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                res_valid,
    input  erle_pkg::result_t   res,
    output logic                slot_free,
    output logic                out_valid,
    input  logic                out_ready,
    output erle_pkg::result_t   out_res
);

    logic              valid_reg;
    logic              valid_next;
    erle_pkg::result_t res_reg;

    // The slot can take a result when empty or being drained this cycle
    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = res_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule
